>>> hw/rtl/bpt_pkg.sv
// Shared types, constants and arithmetic helpers for the brightest point tracker.
// Has no dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package bpt_pkg;

  // Field widths.
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned SUM_W        = 10;
  localparam int unsigned TGT_W        = 28;
  localparam int unsigned CONF_W       = 16;
  localparam int unsigned DIM_W        = 13;
  localparam int unsigned STRIDE_W     = 8;
  localparam int unsigned ALPHA_W      = 17;
  localparam int unsigned ALPHA_FRAC_W = 16;
  localparam int unsigned FRAC_W       = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RST       = 8'd1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST        = 17'd0;

  // floor(peak * 32768 / 765) equals (peak * CONF_MULT) >> CONF_SHIFT for every
  // peak up to 765, with CONF_MULT = ceil(2^35 / 765).
  localparam int unsigned       CONF_MULT_W = 26;
  localparam logic [25:0]       CONF_MULT   = 26'd44914691;
  localparam int unsigned       CONF_SHIFT  = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1,
    REG_SAMPLE_STRIDE = 8'd2,
    REG_EMA_ALPHA    = 8'd3
  } cfg_reg_e;

  // Status of the raster scanner as seen by the peak tracker.
  typedef struct packed {
    logic busy;
    logic sampled;
    logic frame_end;
  } scan_status_t;

  // Peak of one finished frame, position already in Q12.16.
  typedef struct packed {
    logic [TGT_W-1:0] x_q16;
    logic [TGT_W-1:0] y_q16;
    logic [SUM_W-1:0] peak;
  } frame_peak_t;

  // Last valid index for a frame dimension: zero reads as one, and anything
  // above the maximum saturates to it.
  function automatic logic [DIM_W:0] clamp_last(input logic [DIM_W-1:0] v,
                                                input int unsigned      maxv);
    logic [DIM_W:0] ext;
    ext = {1'b0, v};
    if (v == '0) begin
      return '0;
    end else if (ext > (DIM_W+1)'(maxv)) begin
      return (DIM_W+1)'(maxv - 1);
    end else begin
      return ext - (DIM_W+1)'(1);
    end
  endfunction

  // One step of a restoring remainder: shift in one dividend bit.
  function automatic logic [STRIDE_W-1:0] rem_step(input logic [STRIDE_W-1:0] rem,
                                                   input logic                bit_in,
                                                   input logic [STRIDE_W-1:0] divisor);
    logic [STRIDE_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, divisor}) begin
      t = t - {1'b0, divisor};
    end
    return t[STRIDE_W-1:0];
  endfunction

  // prev * (1 - a) + now * a, truncated, rewritten as prev + floor((now - prev) * a)
  // so that one signed multiplier does the work.
  function automatic logic [TGT_W-1:0] ema_blend(input logic [TGT_W-1:0]        prev,
                                                 input logic [TGT_W-1:0]        now,
                                                 input logic [ALPHA_FRAC_W-1:0] alpha);
    logic signed [TGT_W:0]                diff;
    logic signed [TGT_W+ALPHA_FRAC_W+1:0] prod;
    logic signed [TGT_W+ALPHA_FRAC_W+1:0] delta;
    diff  = $signed({1'b0, now}) - $signed({1'b0, prev});
    prod  = diff * $signed({1'b0, alpha});
    delta = prod >>> ALPHA_FRAC_W;
    return prev + delta[TGT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bpt_if.sv
// Channel interfaces of the brightest point tracker: pixels in, results out, config writes.
// Depends on bpt_pkg for the field widths.
`default_nettype none

interface bpt_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [bpt_pkg::PIX_W-1:0]     blue;
  logic [bpt_pkg::PIX_W-1:0]     green;
  logic [bpt_pkg::PIX_W-1:0]     red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface bpt_result_if;
  logic                          valid;
  logic                          ready;
  logic [bpt_pkg::TGT_W-1:0]     target_x_q16;
  logic [bpt_pkg::TGT_W-1:0]     target_y_q16;
  logic [bpt_pkg::CONF_W-1:0]    confidence_q15;
  logic [bpt_pkg::SUM_W-1:0]     peak_sum;

  modport source (output valid, output target_x_q16, output target_y_q16,
                  output confidence_q15, output peak_sum, input ready);
  modport sink   (input valid, input target_x_q16, input target_y_q16,
                  input confidence_q15, input peak_sum, output ready);
endinterface

interface bpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpt_pkg::CFG_IDX_W-1:0]   index;
  logic [bpt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/brightest_point_tracker_unit.sv
// Top level of the brightest point tracker: configuration registers and the three stages.
// Depends on bpt_pkg, bpt_if, bpt_raster_scan, bpt_peak_track and bpt_smooth.
// A frame's result goes from the input register through the peak register to the result register.
// Throughput: one pixel per cycle unless a stride recompute or a full result path stalls the input.
// A write to the stride register holds off pixels, one bit of the wider counter per step,
// while the column and row remainder steps realign the sampling grid.
// Reset clears counters, peak search, smoothing history and the valid flags, and loads the
// configuration defaults (640 by 480, stride 1, smoothing off).
`default_nettype none

module brightest_point_tracker_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bpt_pixel_if.sink    pix_i,
  bpt_result_if.source res_o,
  bpt_cfg_if.sink      cfg_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // Configuration registers, held as written; clamping happens below.
  logic [bpt_pkg::DIM_W-1:0]    frame_width_q;
  logic [bpt_pkg::DIM_W-1:0]    frame_height_q;
  logic [bpt_pkg::STRIDE_W-1:0] stride_q;
  logic [bpt_pkg::ALPHA_W-1:0]  alpha_q;
  logic                         cfg_go;
  logic                         div_start;

  // Geometry and smoothing controls derived from the registers.
  logic [COL_W-1:0]             last_col, half_col;
  logic [ROW_W-1:0]             last_row, half_row;
  logic [COL_W:0]               width_eff;
  logic [ROW_W:0]               height_eff;
  logic [bpt_pkg::STRIDE_W-1:0] stride_eff;
  logic                         smooth_en;

  // Stage interconnect.
  logic [COL_W-1:0]             col;
  logic [ROW_W-1:0]             row;
  bpt_pkg::scan_status_t        scan_status;
  logic                         advance;
  logic                         frm_valid, frm_ready;
  bpt_pkg::frame_peak_t         frm;

  // The configuration port never stalls. A transfer to an index outside the
  // register list is taken and ignored.
  assign cfg_i.ready = 1'b1;
  assign cfg_go      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bpt_pkg::FRAME_WIDTH_RST;
      frame_height_q <= bpt_pkg::FRAME_HEIGHT_RST;
      stride_q       <= bpt_pkg::STRIDE_RST;
      alpha_q        <= bpt_pkg::ALPHA_RST;
    end else if (cfg_go) begin
      case (cfg_i.index)
        bpt_pkg::REG_FRAME_WIDTH:   frame_width_q  <= cfg_i.data[bpt_pkg::DIM_W-1:0];
        bpt_pkg::REG_FRAME_HEIGHT:  frame_height_q <= cfg_i.data[bpt_pkg::DIM_W-1:0];
        bpt_pkg::REG_SAMPLE_STRIDE: stride_q       <= cfg_i.data[bpt_pkg::STRIDE_W-1:0];
        bpt_pkg::REG_EMA_ALPHA:     alpha_q        <= cfg_i.data[bpt_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // A new stride invalidates the sampling phases, which are count % stride
  // kept incrementally; the scanner rebuilds them from the counters.
  assign div_start = cfg_go && (cfg_i.index == bpt_pkg::REG_SAMPLE_STRIDE);

  // A zero dimension counts as one and an oversized one saturates, so the
  // last index always fits the counters.
  assign last_col   = COL_W'(bpt_pkg::clamp_last(frame_width_q, MAX_WIDTH));
  assign last_row   = ROW_W'(bpt_pkg::clamp_last(frame_height_q, MAX_HEIGHT));
  assign width_eff  = {1'b0, last_col} + (COL_W+1)'(1);
  assign height_eff = {1'b0, last_row} + (ROW_W+1)'(1);
  assign half_col   = width_eff[COL_W:1];
  assign half_row   = height_eff[ROW_W:1];

  assign stride_eff = (stride_q == '0) ? bpt_pkg::STRIDE_W'(1) : stride_q;

  // Smoothing runs only for a weight strictly between zero and one; any value
  // with the top bit set is one or above and passes the position through.
  assign smooth_en = (alpha_q != '0) && !alpha_q[bpt_pkg::ALPHA_W-1];

  bpt_raster_scan #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .div_start_i (div_start),
    .last_col_i  (last_col),
    .last_row_i  (last_row),
    .stride_i    (stride_eff),
    .col_o       (col),
    .row_o       (row),
    .status_o    (scan_status)
  );

  // Input register and peak search. Pixels keep flowing while finished results
  // wait in the peak and output registers; only a frame end that finds both
  // of them occupied and the output not ready stalls, besides a stride recompute.
  bpt_peak_track #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_peak (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .col_i       (col),
    .row_i       (row),
    .half_col_i  (half_col),
    .half_row_i  (half_row),
    .scan_i      (scan_status),
    .advance_o   (advance),
    .frm_ready_i (frm_ready),
    .frm_valid_o (frm_valid),
    .frm_o       (frm)
  );

  bpt_smooth u_smooth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_i       (frm),
    .frm_ready_o (frm_ready),
    .smooth_en_i (smooth_en),
    .alpha_i     (alpha_q[bpt_pkg::ALPHA_FRAC_W-1:0]),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bpt_raster_scan.sv
// Column and row counters, sampling grid phases and the remainder unit that
// realigns the phases after a stride change. Depends on bpt_pkg.
`default_nettype none

module bpt_raster_scan #(
  parameter int unsigned COL_W = 12,
  parameter int unsigned ROW_W = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic                           div_start_i,
  input  wire logic [COL_W-1:0]               last_col_i,
  input  wire logic [ROW_W-1:0]               last_row_i,
  input  wire logic [bpt_pkg::STRIDE_W-1:0]   stride_i,
  output logic      [COL_W-1:0]               col_o,
  output logic      [ROW_W-1:0]               row_o,
  output bpt_pkg::scan_status_t               status_o
);

  localparam int unsigned DIV_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  logic [COL_W-1:0]             col_q, col_d;
  logic [ROW_W-1:0]             row_q, row_d;
  logic [bpt_pkg::STRIDE_W-1:0] col_ph_q, col_ph_d;
  logic [bpt_pkg::STRIDE_W-1:0] row_ph_q, row_ph_d;
  logic [bpt_pkg::STRIDE_W-1:0] col_ph_inc, row_ph_inc;
  logic                         busy_q, busy_d;
  logic [STEP_W-1:0]            step_q, step_d;
  logic [DIV_W-1:0]             col_x, row_x;
  logic                         row_end, frame_end;

  assign col_x     = DIV_W'(col_q);
  assign row_x     = DIV_W'(row_q);
  assign row_end   = (col_q >= last_col_i);
  assign frame_end = row_end && (row_q >= last_row_i);

  assign col_ph_inc = (col_ph_q + bpt_pkg::STRIDE_W'(1) == stride_i) ? '0
                    : col_ph_q + bpt_pkg::STRIDE_W'(1);
  assign row_ph_inc = (row_ph_q + bpt_pkg::STRIDE_W'(1) == stride_i) ? '0
                    : row_ph_q + bpt_pkg::STRIDE_W'(1);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    col_ph_d = col_ph_q;
    row_ph_d = row_ph_q;
    busy_d   = busy_q;
    step_d   = step_q;
    if (div_start_i) begin
      // Recompute both phases as count % stride, most significant bit first.
      busy_d   = 1'b1;
      step_d   = STEP_W'(DIV_W - 1);
      col_ph_d = '0;
      row_ph_d = '0;
    end else if (busy_q) begin
      col_ph_d = bpt_pkg::rem_step(col_ph_q, col_x[step_q], stride_i);
      row_ph_d = bpt_pkg::rem_step(row_ph_q, row_x[step_q], stride_i);
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end else if (advance_i) begin
      if (frame_end) begin
        col_d    = '0;
        row_d    = '0;
        col_ph_d = '0;
        row_ph_d = '0;
      end else if (row_end) begin
        col_d    = '0;
        row_d    = row_q + ROW_W'(1);
        col_ph_d = '0;
        row_ph_d = row_ph_inc;
      end else begin
        col_d    = col_q + COL_W'(1);
        col_ph_d = col_ph_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      col_ph_q <= '0;
      row_ph_q <= '0;
      busy_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      col_ph_q <= col_ph_d;
      row_ph_q <= row_ph_d;
      busy_q   <= busy_d;
      step_q   <= step_d;
    end
  end

  assign col_o              = col_q;
  assign row_o              = row_q;
  assign status_o.busy      = busy_q || div_start_i;
  assign status_o.sampled   = (col_ph_q == '0) && (row_ph_q == '0);
  assign status_o.frame_end = frame_end;

  a_no_advance_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !advance_i)
    else $error("pixel consumed while the phase recompute is running");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !div_start_i) |-> (col_ph_q < stride_i && row_ph_q < stride_i))
    else $error("sampling phase out of range for the current stride");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && frame_end && !busy_q && !div_start_i) |=>
      (col_q == '0 && row_q == '0 && col_ph_q == '0 && row_ph_q == '0))
    else $error("counters not cleared after the last pixel of a frame");

endmodule

`default_nettype wire

>>> hw/rtl/bpt_peak_track.sv
// Pixel input register, brightest sampled pixel search and the per-frame peak register.
// Depends on bpt_pkg, bpt_if and the status of bpt_raster_scan.
`default_nettype none

module bpt_peak_track #(
  parameter int unsigned COL_W = 12,
  parameter int unsigned ROW_W = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  bpt_pixel_if.sink                   pix_i,
  input  wire logic [COL_W-1:0]       col_i,
  input  wire logic [ROW_W-1:0]       row_i,
  input  wire logic [COL_W-1:0]       half_col_i,
  input  wire logic [ROW_W-1:0]       half_row_i,
  input  wire bpt_pkg::scan_status_t  scan_i,
  output logic                        advance_o,
  input  wire logic                   frm_ready_i,
  output logic                        frm_valid_o,
  output bpt_pkg::frame_peak_t        frm_o
);

  logic                          pix_vld_q;
  logic [bpt_pkg::PIX_W-1:0]     blue_q, green_q, red_q;
  logic                          pix_go, pix_take;
  logic [bpt_pkg::SUM_W-1:0]     sum;
  logic                          take;

  logic                          best_valid_q, best_valid_d;
  logic [bpt_pkg::SUM_W-1:0]     best_sum_q, best_sum_d;
  logic [COL_W-1:0]              best_col_q, best_col_d;
  logic [ROW_W-1:0]              best_row_q, best_row_d;

  logic                          frm_vld_q, frm_vld_d;
  bpt_pkg::frame_peak_t          frm_q, frm_d;
  logic [COL_W-1:0]              end_col;
  logic [ROW_W-1:0]              end_row;
  logic [bpt_pkg::SUM_W-1:0]     end_sum;

  assign sum = bpt_pkg::SUM_W'(blue_q) + bpt_pkg::SUM_W'(green_q)
             + bpt_pkg::SUM_W'(red_q);

  // A pixel that closes a frame may only leave when the peak register is free or being emptied.
  assign pix_go    = pix_vld_q && !scan_i.busy
                   && (!scan_i.frame_end || !frm_vld_q || frm_ready_i);
  assign pix_take  = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !pix_vld_q || pix_go;
  assign advance_o = pix_go;

  // Strictly greater keeps the first pixel of equal brightness.
  assign take = scan_i.sampled && (!best_valid_q || sum > best_sum_q);

  always_comb begin
    if (take) begin
      end_col = col_i;
      end_row = row_i;
      end_sum = sum;
    end else if (best_valid_q) begin
      end_col = best_col_q;
      end_row = best_row_q;
      end_sum = best_sum_q;
    end else begin
      end_col = half_col_i;
      end_row = half_row_i;
      end_sum = '0;
    end
  end

  always_comb begin
    best_valid_d = best_valid_q;
    best_sum_d   = best_sum_q;
    best_col_d   = best_col_q;
    best_row_d   = best_row_q;
    frm_vld_d    = frm_ready_i ? 1'b0 : frm_vld_q;
    frm_d        = frm_q;
    if (pix_go) begin
      if (scan_i.frame_end) begin
        frm_vld_d     = 1'b1;
        frm_d.x_q16   = bpt_pkg::TGT_W'(end_col) << bpt_pkg::FRAC_W;
        frm_d.y_q16   = bpt_pkg::TGT_W'(end_row) << bpt_pkg::FRAC_W;
        frm_d.peak    = end_sum;
        best_valid_d  = 1'b0;
        best_sum_d    = '0;
        best_col_d    = '0;
        best_row_d    = '0;
      end else if (take) begin
        best_valid_d = 1'b1;
        best_sum_d   = sum;
        best_col_d   = col_i;
        best_row_d   = row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q    <= 1'b0;
      best_valid_q <= 1'b0;
      best_sum_q   <= '0;
      best_col_q   <= '0;
      best_row_q   <= '0;
      frm_vld_q    <= 1'b0;
    end else begin
      if (pix_take) begin
        pix_vld_q <= 1'b1;
      end else if (pix_go) begin
        pix_vld_q <= 1'b0;
      end
      best_valid_q <= best_valid_d;
      best_sum_q   <= best_sum_d;
      best_col_q   <= best_col_d;
      best_row_q   <= best_row_d;
      frm_vld_q    <= frm_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take) begin
      blue_q  <= pix_i.blue;
      green_q <= pix_i.green;
      red_q   <= pix_i.red;
    end
    frm_q <= frm_d;
  end

  assign frm_valid_o = frm_vld_q;
  assign frm_o       = frm_q;

  a_frame_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_go && scan_i.frame_end) |=> (frm_vld_q && !best_valid_q))
    else $error("frame end did not hand over the peak and clear the search");

endmodule

`default_nettype wire

>>> hw/rtl/bpt_smooth.sv
// Exponential smoothing of the peak position, confidence scaling and the result register.
// Depends on bpt_pkg and bpt_if.
`default_nettype none

module bpt_smooth (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              frm_valid_i,
  input  wire bpt_pkg::frame_peak_t              frm_i,
  output logic                                   frm_ready_o,
  input  wire logic                              smooth_en_i,
  input  wire logic [bpt_pkg::ALPHA_FRAC_W-1:0]  alpha_i,
  bpt_result_if.source                           res_o
);

  localparam int unsigned CONF_PROD_W = bpt_pkg::SUM_W + bpt_pkg::CONF_MULT_W;

  logic                          out_vld_q;
  logic                          load;
  logic                          has_last_q;
  logic [bpt_pkg::TGT_W-1:0]     last_x_q, last_y_q;
  logic [bpt_pkg::TGT_W-1:0]     x_res, y_res;
  logic [CONF_PROD_W-1:0]        conf_prod;
  logic [bpt_pkg::TGT_W-1:0]     tx_q, ty_q;
  logic [bpt_pkg::CONF_W-1:0]    conf_q;
  logic [bpt_pkg::SUM_W-1:0]     peak_q;

  assign frm_ready_o = !out_vld_q || res_o.ready;
  assign load        = frm_valid_i && frm_ready_o;

  always_comb begin
    if (smooth_en_i && has_last_q) begin
      x_res = bpt_pkg::ema_blend(last_x_q, frm_i.x_q16, alpha_i);
      y_res = bpt_pkg::ema_blend(last_y_q, frm_i.y_q16, alpha_i);
    end else begin
      x_res = frm_i.x_q16;
      y_res = frm_i.y_q16;
    end
  end

  assign conf_prod = CONF_PROD_W'(frm_i.peak) * CONF_PROD_W'(bpt_pkg::CONF_MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      has_last_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (load && smooth_en_i) begin
        has_last_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_q   <= x_res;
      ty_q   <= y_res;
      conf_q <= conf_prod[bpt_pkg::CONF_SHIFT +: bpt_pkg::CONF_W];
      peak_q <= frm_i.peak;
      if (smooth_en_i) begin
        last_x_q <= x_res;
        last_y_q <= y_res;
      end
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.target_x_q16   = tx_q;
  assign res_o.target_y_q16   = ty_q;
  assign res_o.confidence_q15 = conf_q;
  assign res_o.peak_sum       = peak_q;

  a_history_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && smooth_en_i) |=>
      (has_last_q && last_x_q == res_o.target_x_q16 && last_y_q == res_o.target_y_q16))
    else $error("smoothing history differs from the position just sent");

endmodule

`default_nettype wire
